// ----- src/kped_pkg.sv -----
// Package for the key press event detector: sizes, register indexes,
// reset values and the per-key event and event-bitmap types.
// No dependencies.
package kped_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int COUNT_BITS = 12;

    localparam int KEY_W   = 16;
    localparam int TICK_W  = 12;
    localparam int START_W = 3;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 16;
    localparam int OUT_W   = 120;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_KEY_ENABLE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG_TICKS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_DOUBLE_TICKS = 2'd2;
    localparam logic [IDX_W-1:0] REG_STARTUP      = 2'd3;

    localparam logic [KEY_W-1:0]   RST_KEY_ENABLE   = 16'h0000;
    localparam logic [TICK_W-1:0]  RST_LONG_TICKS   = 12'd100;
    localparam logic [TICK_W-1:0]  RST_DOUBLE_TICKS = 12'd30;
    localparam logic [START_W-1:0] RST_STARTUP      = 3'd3;

    // Events raised by one key on one scan tick.
    typedef struct packed {
        logic long_press;
        logic single_press;
        logic double_press;
        logic short_press;
        logic key_up;
        logic key_down;
    } key_ev_t;

    // Six event bitmaps; key down sits in the lowest bits.
    typedef struct packed {
        logic [KEY_W-1:0] long_press;
        logic [KEY_W-1:0] single_press;
        logic [KEY_W-1:0] double_press;
        logic [KEY_W-1:0] short_press;
        logic [KEY_W-1:0] key_up;
        logic [KEY_W-1:0] key_down;
    } ev_map_t;

endpackage

// ----- src/kped_key_lane.sv -----
// One key lane: debounce sample, debounced level, long-press and
// double-window counters, and the events of one scan tick.
// Depends on kped_pkg.
module kped_key_lane
    import kped_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick,
    input  logic    key_en,
    input  logic    sample,
    input  count_t  long_ticks,
    input  count_t  double_ticks,
    output logic    deb_level,
    output logic    new_level,
    output key_ev_t events
);

    logic   prev_reg;
    logic   deb_reg;
    count_t long_cnt_reg;
    count_t long_cnt_next;
    count_t dbl_cnt_reg;
    count_t dbl_cnt_next;

    logic   rise;
    logic   fall;
    count_t long_loaded;
    count_t dbl_after_rel;

    always_comb begin
        new_level     = key_en & sample & prev_reg;
        rise          = key_en & new_level & ~deb_reg;
        fall          = key_en & ~new_level & deb_reg;
        events        = '0;
        long_loaded   = rise ? long_ticks : long_cnt_reg;
        long_cnt_next = long_loaded;
        dbl_after_rel = dbl_cnt_reg;

        events.key_down = rise;
        events.key_up   = fall;

        if (new_level && long_loaded != '0) begin
            long_cnt_next     = long_loaded - count_t'(1);
            events.long_press = (long_loaded == count_t'(1));
        end

        // A release while the long count still runs is a short press, or
        // the second half of a double press if the window is open.
        if (fall && long_cnt_reg != '0) begin
            if (dbl_cnt_reg == '0) begin
                events.short_press = 1'b1;
                dbl_after_rel      = double_ticks;
            end else begin
                events.double_press = 1'b1;
                dbl_after_rel       = '0;
            end
        end

        dbl_cnt_next = dbl_after_rel;
        if (key_en && dbl_after_rel != '0) begin
            events.single_press = (dbl_after_rel == count_t'(1));
            dbl_cnt_next        = dbl_after_rel - count_t'(1);
        end
    end

    assign deb_level = deb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= 1'b0;
            deb_reg      <= 1'b0;
            long_cnt_reg <= '0;
            dbl_cnt_reg  <= '0;
        end else if (tick) begin
            deb_reg <= new_level;
            if (key_en) begin
                prev_reg     <= sample;
                long_cnt_reg <= long_cnt_next;
                dbl_cnt_reg  <= dbl_cnt_next;
            end
        end
    end

endmodule

// ----- src/kped_event_store.sv -----
// Sticky event bitmaps with the startup suppress counter; gives the
// bitmaps and pending flag that a scan tick or a read returns.
// Depends on kped_pkg.
module kped_event_store
    import kped_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               scan_tick,
    input  logic               read_req,
    input  logic               startup_load,
    input  logic [START_W-1:0] startup_value,
    input  ev_map_t            new_ev,
    output ev_map_t            result_ev,
    output logic               pending
);

    ev_map_t            flags_reg;
    ev_map_t            flags_next;
    logic [START_W-1:0] start_cnt_reg;
    logic [START_W-1:0] start_cnt_next;

    always_comb begin
        flags_next     = flags_reg;
        start_cnt_next = start_cnt_reg;
        result_ev      = flags_reg;
        pending        = |flags_reg;
        if (scan_tick) begin
            flags_next = flags_reg | new_ev;
            if (start_cnt_reg != '0) begin
                start_cnt_next = start_cnt_reg - START_W'(1);
                flags_next     = '0;
            end
            result_ev = flags_next;
            pending   = |flags_next;
        end else if (read_req) begin
            flags_next = '0;
            pending    = 1'b0;
        end
        if (startup_load) begin
            start_cnt_next = startup_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            start_cnt_reg <= RST_STARTUP;
        end else begin
            flags_reg     <= flags_next;
            start_cnt_reg <= start_cnt_next;
        end
    end

endmodule

// ----- src/key_press_event_detector.sv -----
// Key press event detector, top level. An input transfer reaches its result
// transfer through the input register, then the result register;
// one item is accepted every cycle while the result side keeps up.
// Reset (aresetn, synchronous, active low) clears all key state and event
// bitmaps, loads the configuration reset values and starts the startup
// suppress count at three ticks. Depends on kped_pkg and the lane/store modules.
module key_press_event_detector
    import kped_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEY_W-1:0]  s_tdata,   // [15:0] raw_keys
    input  logic              s_tuser,   // [0] req_type: 0 scan tick, 1 read and clear
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    // [15:0] keydown_events, [31:16] keyup_events, [47:32] short_press_events,
    // [63:48] double_press_events, [79:64] single_press_events,
    // [95:80] long_press_events, [111:96] debounced_keys,
    // [112] event_pending, [119:113] zero
    output logic [OUT_W-1:0]  m_tdata,
    // Configuration write port.
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    // Configuration registers.
    logic [KEY_W-1:0]  enable_reg;
    logic [TICK_W-1:0] long_ticks_reg;
    logic [TICK_W-1:0] double_ticks_reg;
    logic              startup_load;

    // Input register.
    logic              in_valid_reg;
    logic              in_read_reg;
    logic [KEY_W-1:0]  in_keys_reg;

    // Result register.
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              advance;
    logic              step;
    logic              scan_tick;
    logic              read_req;

    logic [KEY_W-1:0]  deb_vec;
    logic [KEY_W-1:0]  level_vec;
    key_ev_t           lane_ev [KEY_W];
    ev_map_t           new_ev;
    ev_map_t           result_ev;
    logic              pending;
    logic [KEY_W-1:0]  result_deb;

    // The result register frees up when it is empty or its transfer
    // completes; the input register then hands its item over in the same
    // cycle, so the input side is ready whenever that hand-over happens.
    assign advance   = ~out_valid_reg | m_tready;
    assign step      = in_valid_reg & advance;
    assign scan_tick = step & ~in_read_reg;
    assign read_req  = step & in_read_reg;
    assign s_tready  = ~in_valid_reg | advance;

    always_comb begin
        startup_load = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STARTUP: startup_load = 1'b1;
                default:     startup_load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= RST_KEY_ENABLE;
            long_ticks_reg   <= RST_LONG_TICKS;
            double_ticks_reg <= RST_DOUBLE_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY_ENABLE:   enable_reg       <= cfg_wdata;
                REG_LONG_TICKS:   long_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                REG_DOUBLE_TICKS: double_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // One lane per scanned key. Positions beyond NUM_KEYS behave as
    // disabled keys: level zero and no events.
    for (genvar k = 0; k < KEY_W; k++) begin : g_lane
        if (k < NUM_KEYS) begin : g_key
            kped_key_lane u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .tick         (scan_tick),
                .key_en       (enable_reg[k]),
                .sample       (in_keys_reg[k]),
                .long_ticks   (count_t'(long_ticks_reg)),
                .double_ticks (count_t'(double_ticks_reg)),
                .deb_level    (deb_vec[k]),
                .new_level    (level_vec[k]),
                .events       (lane_ev[k])
            );
        end else begin : g_none
            assign deb_vec[k]   = 1'b0;
            assign level_vec[k] = 1'b0;
            assign lane_ev[k]   = '0;
        end
        assign new_ev.key_down[k]     = lane_ev[k].key_down;
        assign new_ev.key_up[k]       = lane_ev[k].key_up;
        assign new_ev.short_press[k]  = lane_ev[k].short_press;
        assign new_ev.double_press[k] = lane_ev[k].double_press;
        assign new_ev.single_press[k] = lane_ev[k].single_press;
        assign new_ev.long_press[k]   = lane_ev[k].long_press;
    end

    kped_event_store u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scan_tick     (scan_tick),
        .read_req      (read_req),
        .startup_load  (startup_load),
        .startup_value (cfg_wdata[START_W-1:0]),
        .new_ev        (new_ev),
        .result_ev     (result_ev),
        .pending       (pending)
    );

    // A scan tick reports the level it just computed; a read reports the
    // level left by the last tick.
    assign result_deb = in_read_reg ? deb_vec : level_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_read_reg <= s_tuser;
            in_keys_reg <= s_tdata;
        end
        if (step) begin
            out_data_reg <= {7'b0, pending, result_deb, result_ev};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
